// File: rtl/core/mcpr_pkg.sv
// Shared codes and the pixel record for the motion-compensated reconstruction block.
`default_nettype none

package mcpr_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_INTRA = 2'd0;
  localparam logic [1:0] KIND_INTER = 2'd1;
  localparam logic [1:0] KIND_SWAP  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_MB_WIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MB_HIGH = 1'd1;

  // Plane coordinates and clamped reference coordinates.
  localparam int PIX_W = 9;
  localparam int REF_W = 10;

  // One pixel in flight: its own position, its reference position and its residual.
  typedef struct packed {
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic [REF_W-1:0]  rx;
    logic [REF_W-1:0]  ry;
    logic              inter;
    logic              sel;
    logic signed [15:0] residual;
  } pix_t;

endpackage

`default_nettype wire

// File: rtl/core/motion_comp_pixel_reconstruct.sv
// Top level: motion-compensated pixel reconstruction into two swapping frame stores.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in_     | in        | in_valid/in_ready   | kind, block_col/row, pixel_index, motion, res
//  out_    | out       | out_valid/out_ready | pixel_x, pixel_y, pixel_value
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One beat per cycle sustained while the output is not stalled; a pixel passes the
// coordinate register, the frame store read with stage 2 and the output register before
// its result is valid. Each pixel needs one registered read and one write of frame memory.
// Swap, reserved and out-of-plane beats are taken and dropped at the input stage.
// Reset (rst_n low, synchronous) empties the pipeline and makes store a the reference;
// store contents stay as they are. Output stalls fill the output register and both
// internal stages (three pixels), then drop in_ready.
`default_nettype none

module motion_comp_pixel_reconstruct #(
  parameter int MAX_BLOCKS_WIDE    = 32,
  parameter int MAX_BLOCKS_HIGH    = 32,
  parameter int RESIDUAL_FRAC_BITS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [4:0]                          in_block_col,
  input  wire logic [4:0]                          in_block_row,
  input  wire logic [7:0]                          in_pixel_index,
  input  wire logic signed [6:0]                   in_motion_x,
  input  wire logic signed [6:0]                   in_motion_y,
  input  wire logic signed [15:0]                  in_residual,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [mcpr_pkg::PIX_W-1:0]               out_pixel_x,
  output logic [mcpr_pkg::PIX_W-1:0]               out_pixel_y,
  output logic [7:0]                               out_pixel_value,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mcpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mcpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int STRIDE    = MAX_BLOCKS_WIDE * 16;
  localparam int DEPTH     = STRIDE * MAX_BLOCKS_HIGH * 16;
  localparam int AW        = $clog2(DEPTH);
  localparam int CFG_LIMIT = (1 << mcpr_pkg::CFG_DATA_W) - 1;
  localparam int EFF_MAX_W = (MAX_BLOCKS_WIDE < CFG_LIMIT) ? MAX_BLOCKS_WIDE : CFG_LIMIT;
  localparam int EFF_MAX_H = (MAX_BLOCKS_HIGH < CFG_LIMIT) ? MAX_BLOCKS_HIGH : CFG_LIMIT;

  // Effective plane size in macroblocks, already limited to 1..MAX.
  logic [mcpr_pkg::CFG_DATA_W-1:0] mb_cols_r;
  logic [mcpr_pkg::CFG_DATA_W-1:0] mb_rows_r;
  logic [mcpr_pkg::CFG_DATA_W-1:0] eff_w_nxt;
  logic [mcpr_pkg::CFG_DATA_W-1:0] eff_h_nxt;
  logic                            cfg_acc;

  logic            s1_valid;
  logic            s1_go;
  mcpr_pkg::pix_t  s1_item;
  logic            ref_sel;
  logic            s2_free;
  logic            s2_go;
  logic            wr_sel;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   s1_wr_addr;
  logic            fwd_match;
  logic            we_a;
  logic            we_b;
  logic [7:0]      q_a;
  logic [7:0]      q_b;

  // Configuration: always ready, values sanitized on the way in.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == '0) begin
      eff_w_nxt = 6'd1;
    end else if (int'(cfg_data) > EFF_MAX_W) begin
      eff_w_nxt = 6'(EFF_MAX_W);
    end else begin
      eff_w_nxt = cfg_data;
    end
    if (cfg_data == '0) begin
      eff_h_nxt = 6'd1;
    end else if (int'(cfg_data) > EFF_MAX_H) begin
      eff_h_nxt = 6'(EFF_MAX_H);
    end else begin
      eff_h_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mb_cols_r <= 6'd1;
      mb_rows_r <= 6'd1;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        mcpr_pkg::CFG_MB_WIDE: mb_cols_r <= eff_w_nxt;
        mcpr_pkg::CFG_MB_HIGH: mb_rows_r <= eff_h_nxt;
        default: ;
      endcase
    end
  end

  // Stage 1: positions, plane check, store tag.
  mcpr_coord u_coord (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_block_col   (in_block_col),
    .in_block_row   (in_block_row),
    .in_pixel_index (in_pixel_index),
    .in_motion_x    (in_motion_x),
    .in_motion_y    (in_motion_y),
    .in_residual    (in_residual),
    .mb_cols        (mb_cols_r),
    .mb_rows        (mb_rows_r),
    .s2_free        (s2_free),
    .s1_valid       (s1_valid),
    .s1_go          (s1_go),
    .s1_item        (s1_item),
    .ref_sel        (ref_sel)
  );

  // Linear store addresses, row stride fixed by the largest plane.
  assign rd_addr    = AW'(int'(s1_item.ry) * STRIDE + int'(s1_item.rx));
  assign s1_wr_addr = AW'(int'(s1_item.py) * STRIDE + int'(s1_item.px));

  // The beat in stage 2 writes its destination store while the beat in stage 1
  // reads; after a swap these can be the same store and entry. Flag it so the
  // stage 2 value is taken instead of the stale read.
  assign fwd_match = s1_item.inter && (s1_item.sel != wr_sel) && (rd_addr == wr_addr);

  // Reference is store a while sel is 0; the other store is the destination.
  assign we_a = s2_go && wr_sel;
  assign we_b = s2_go && !wr_sel;

  mcpr_frame_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (s1_go),
    .raddr (rd_addr),
    .rdata (q_a)
  );

  mcpr_frame_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (s1_go),
    .raddr (rd_addr),
    .rdata (q_b)
  );

  // Stage 2 and output register.
  mcpr_recon #(.RESIDUAL_FRAC_BITS(RESIDUAL_FRAC_BITS), .AW(AW)) u_recon (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (s1_go),
    .s1_item         (s1_item),
    .wr_addr_in      (s1_wr_addr),
    .fwd_match       (fwd_match),
    .q_a             (q_a),
    .q_b             (q_b),
    .s2_free         (s2_free),
    .s2_go           (s2_go),
    .wr_sel          (wr_sel),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_value (out_pixel_value)
  );

`ifndef NO_ASSERTIONS
  a_swap_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == mcpr_pkg::KIND_SWAP |=> ref_sel != $past(ref_sel))
    else $error("swap beat did not flip the reference store");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid |-> int'(rd_addr) < DEPTH)
    else $error("reference read beyond the frame store");

  a_one_store_written: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_a && we_b))
    else $error("both frame stores written in one cycle");

  a_out_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_pixel_x} < {mb_cols_r, 4'b0000})
               && ({1'b0, out_pixel_y} < {mb_rows_r, 4'b0000}))
    else $error("result beat outside the configured plane");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ready)
    else $error("input stalled with the first stage empty");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mcpr_frame_store.sv
// One frame store: single write port, single registered read port.
`default_nettype none

module mcpr_frame_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/mcpr_coord.sv
// Input stage: pixel position, plane check, clamped reference position, store select.
`default_nettype none

module mcpr_coord (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_kind,
  input  wire logic [4:0]          in_block_col,
  input  wire logic [4:0]          in_block_row,
  input  wire logic [7:0]          in_pixel_index,
  input  wire logic signed [6:0]   in_motion_x,
  input  wire logic signed [6:0]   in_motion_y,
  input  wire logic signed [15:0]  in_residual,
  input  wire logic [mcpr_pkg::CFG_DATA_W-1:0] mb_cols,
  input  wire logic [mcpr_pkg::CFG_DATA_W-1:0] mb_rows,
  input  wire logic                s2_free,
  output logic                     s1_valid,
  output logic                     s1_go,
  output mcpr_pkg::pix_t           s1_item,
  output logic                     ref_sel
);

  logic                         s1_valid_r;
  logic                         ref_sel_r;
  mcpr_pkg::pix_t               item_r;
  mcpr_pkg::pix_t               item_nxt;
  logic                         in_acc;
  logic                         is_pixel;
  logic                         in_plane;
  logic                         take;
  logic [mcpr_pkg::REF_W-1:0]   w_max;
  logic [mcpr_pkg::REF_W-1:0]   h_max;
  logic signed [mcpr_pkg::REF_W:0] sx;
  logic signed [mcpr_pkg::REF_W:0] sy;

  assign in_ready = !s1_valid_r || s2_free;
  assign in_acc   = in_valid && in_ready;
  assign s1_go    = s1_valid_r && s2_free;

  always_comb begin
    case (in_kind) inside
      mcpr_pkg::KIND_INTRA, mcpr_pkg::KIND_INTER: is_pixel = 1'b1;
      default:                                    is_pixel = 1'b0;
    endcase
  end

  assign in_plane = ({1'b0, in_block_col} < mb_cols) && ({1'b0, in_block_row} < mb_rows);
  assign take     = in_acc && is_pixel && in_plane;

  assign w_max = {mb_cols, 4'b0000} - 10'd1;
  assign h_max = {mb_rows, 4'b0000} - 10'd1;

  always_comb begin
    item_nxt.px       = {in_block_col, in_pixel_index[6], in_pixel_index[2:0]};
    item_nxt.py       = {in_block_row, in_pixel_index[7], in_pixel_index[5:3]};
    item_nxt.inter    = (in_kind == mcpr_pkg::KIND_INTER);
    item_nxt.sel      = ref_sel_r;
    item_nxt.residual = in_residual;
    sx = $signed({2'b00, item_nxt.px}) + $signed({{4{in_motion_x[6]}}, in_motion_x});
    sy = $signed({2'b00, item_nxt.py}) + $signed({{4{in_motion_y[6]}}, in_motion_y});
    // Clamp the reference position to the plane.
    if (sx[mcpr_pkg::REF_W]) begin
      item_nxt.rx = '0;
    end else if (sx[mcpr_pkg::REF_W-1:0] > w_max) begin
      item_nxt.rx = w_max;
    end else begin
      item_nxt.rx = sx[mcpr_pkg::REF_W-1:0];
    end
    if (sy[mcpr_pkg::REF_W]) begin
      item_nxt.ry = '0;
    end else if (sy[mcpr_pkg::REF_W-1:0] > h_max) begin
      item_nxt.ry = h_max;
    end else begin
      item_nxt.ry = sy[mcpr_pkg::REF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ref_sel_r  <= 1'b0;
    end else begin
      if (in_acc && in_kind == mcpr_pkg::KIND_SWAP) begin
        ref_sel_r <= !ref_sel_r;
      end
      if (in_ready) begin
        s1_valid_r <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;
  assign ref_sel  = ref_sel_r;

endmodule

`default_nettype wire

// File: rtl/core/mcpr_recon.sv
// Reconstruction stage: reference select with forwarding, sum and clamp, output register.
`default_nettype none

module mcpr_recon #(
  parameter int RESIDUAL_FRAC_BITS = 4,
  parameter int AW                 = 18
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire mcpr_pkg::pix_t         s1_item,
  input  wire logic [AW-1:0]          wr_addr_in,
  input  wire logic                   fwd_match,
  input  wire logic [7:0]             q_a,
  input  wire logic [7:0]             q_b,
  output logic                        s2_free,
  output logic                        s2_go,
  output logic                        wr_sel,
  output logic [AW-1:0]               wr_addr,
  output logic [7:0]                  wr_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [mcpr_pkg::PIX_W-1:0]  out_pixel_x,
  output logic [mcpr_pkg::PIX_W-1:0]  out_pixel_y,
  output logic [7:0]                  out_pixel_value
);

  localparam int TW = 18 + RESIDUAL_FRAC_BITS;

  logic                        s2_valid_r;
  mcpr_pkg::pix_t              item2_r;
  logic [AW-1:0]               wr_addr_r;
  logic                        fwd_hit_r;
  logic [7:0]                  fwd_val_r;
  logic                        out_valid_r;
  logic [mcpr_pkg::PIX_W-1:0]  out_x_r;
  logic [mcpr_pkg::PIX_W-1:0]  out_y_r;
  logic [7:0]                  out_v_r;
  logic                        out_free;
  logic [7:0]                  ref_pix;
  logic signed [TW-1:0]        res_ext;
  logic signed [TW-1:0]        sum;
  logic signed [TW-1:0]        shifted;
  logic [7:0]                  value;

  assign out_free = !out_valid_r || out_ready;
  assign s2_go    = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;

  assign ref_pix = fwd_hit_r ? fwd_val_r : (item2_r.sel ? q_b : q_a);
  assign res_ext = TW'(item2_r.residual);

  always_comb begin
    if (item2_r.inter) begin
      sum = (TW'({1'b0, ref_pix}) <<< RESIDUAL_FRAC_BITS) + (res_ext <<< 1);
    end else begin
      sum = res_ext + (TW'(128) <<< RESIDUAL_FRAC_BITS);
    end
    shifted = sum >>> RESIDUAL_FRAC_BITS;
    if (sum < 0) begin
      value = 8'd0;
    end else if (shifted > TW'(255)) begin
      value = 8'd255;
    end else begin
      value = shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_r <= load;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item2_r   <= s1_item;
      wr_addr_r <= wr_addr_in;
      // The beat leaving now writes the entry the new beat reads: take its value.
      fwd_hit_r <= fwd_match && s2_go;
      fwd_val_r <= value;
    end
    if (s2_go) begin
      out_x_r <= item2_r.px;
      out_y_r <= item2_r.py;
      out_v_r <= value;
    end
  end

  assign wr_sel          = item2_r.sel;
  assign wr_addr         = wr_addr_r;
  assign wr_data         = value;
  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_value = out_v_r;

endmodule

`default_nettype wire
